### design/rbi_pkg.sv
// Package for the ray/box intersection block: widths, payload and config types.
// No dependencies; used by rbi_face and ray_box_intersection.
package rbi_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int FRAC_BITS   = 16;
    localparam int SIZE_WIDTH  = 31;
    localparam int NUM_WIDTH   = 35;   // size + 2*pos, signed
    localparam int QUO_WIDTH   = 34;   // quotient magnitude incl. guard bits
    localparam int DIV_STEPS   = QUO_WIDTH;
    localparam int STAGE_BITS  = 2;    // quotient bits per divider stage
    localparam int DIV_STAGES  = DIV_STEPS / STAGE_BITS;

    localparam logic [SIZE_WIDTH-1:0] SIZE_RESET = 31'd65536;

    localparam logic [1:0] REG_BOX_SIZE_X = 2'd0;
    localparam logic [1:0] REG_BOX_SIZE_Y = 2'd1;
    localparam logic [1:0] REG_BOX_SIZE_Z = 2'd2;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_x;
        logic signed [COORD_WIDTH-1:0] pos_y;
        logic signed [COORD_WIDTH-1:0] pos_z;
        logic signed [COORD_WIDTH-1:0] vel_x;
        logic signed [COORD_WIDTH-1:0] vel_y;
        logic signed [COORD_WIDTH-1:0] vel_z;
    } ray_t;

    typedef struct packed {
        logic                          hit;
        logic signed [COORD_WIDTH-1:0] time_in;
        logic signed [COORD_WIDTH-1:0] time_out;
    } result_t;

    // Per-face operands carried along the pipe
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] pos_b;
        logic signed [COORD_WIDTH-1:0] pos_c;
        logic signed [COORD_WIDTH-1:0] vel_b;
        logic signed [COORD_WIDTH-1:0] vel_c;
        logic [SIZE_WIDTH-1:0]         size_b;
        logic [SIZE_WIDTH-1:0]         size_c;
    } face_ops_t;

endpackage

### design/rbi_face.sv
// One face-time unit: pipelined restoring divider, saturation, hit-point test.
// Depends on rbi_pkg. Advances when en is high.
module rbi_face (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic signed [rbi_pkg::NUM_WIDTH-1:0]   num,
    input  logic signed [rbi_pkg::COORD_WIDTH-1:0] vel,
    input  rbi_pkg::face_ops_t                    ops,
    output logic signed [rbi_pkg::COORD_WIDTH-1:0] t_out
);
    localparam int NW = rbi_pkg::NUM_WIDTH;
    localparam int CW = rbi_pkg::COORD_WIDTH;
    localparam int FB = rbi_pkg::FRAC_BITS;
    localparam int QW = rbi_pkg::QUO_WIDTH;
    localparam int NS = rbi_pkg::DIV_STAGES;
    localparam int SB = rbi_pkg::STAGE_BITS;
    localparam int DW = CW + 1;            // 2*|v| magnitude
    localparam int XW = NW + FB;           // numerator scaled by 2^FB
    localparam int PW = 2 * CW + 2;        // product width
    localparam logic [42:0] CLAMP = 43'h100_0000_0000;

    // Stage 0: magnitudes. Scaled dividend |num|*2^FB, divisor 2|v|.
    logic [XW-1:0]  dvd_reg  [NS+1];
    logic [DW-1:0]  dsr_reg  [NS+1];
    logic [QW-1:0]  quo_reg  [NS+1];
    logic [DW:0]    rem_reg  [NS+1];
    logic           neg_reg  [NS+1];
    logic           nz_reg   [NS+1];
    logic           ovf_reg  [NS+1];
    rbi_pkg::face_ops_t ops_reg [NS+1];

    logic [NW-1:0] num_mag;
    logic [CW:0]   vel_mag;
    assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);
    assign vel_mag = vel[CW-1] ? (CW+1)'(-{vel[CW-1], vel}) : (CW+1)'({1'b0, vel});

    always_ff @(posedge aclk) begin
        if (en) begin
            dvd_reg[0] <= {num_mag, {FB{1'b0}}};
            dsr_reg[0] <= {vel_mag[CW-1:0], 1'b0};
            quo_reg[0] <= '0;
            rem_reg[0] <= '0;
            neg_reg[0] <= num[NW-1] ^ vel[CW-1];
            nz_reg[0]  <= (vel != '0);
            ovf_reg[0] <= 1'b0;
            ops_reg[0] <= ops;
        end
    end

    // Divider stages: SB quotient bits each; dividend bits above QW seed the
    // remainder chain and set the overflow flag when they reach the divisor.
    localparam int HB = XW - QW;           // high dividend bits consumed first
    logic [DW:0] pre_rem;
    logic        pre_ovf;
    always_comb begin
        // Dividend bits above the quotient window: any of them set means
        // quotient >= 2^QW only if their value reaches the divisor; handled by
        // folding them into the initial remainder and flagging if >= divisor.
        pre_rem = '0;
        pre_ovf = 1'b0;
        pre_rem = (DW+1)'(dvd_reg[0][XW-1 -: HB]);
        if (pre_rem >= {1'b0, dsr_reg[0]}) pre_ovf = 1'b1;
    end

    for (genvar s = 0; s < NS; s++) begin : g_div
        logic [DW:0]   r;
        logic [QW-1:0] q;
        always_comb begin
            r = (s == 0) ? pre_rem : rem_reg[s];
            q = quo_reg[s];
            for (int k = 0; k < SB; k++) begin
                r = {r[DW-1:0], dvd_reg[s][QW-1 - (s*SB + k)]};
                q = {q[QW-2:0], 1'b0};
                if (r >= {1'b0, dsr_reg[s]}) begin
                    r = r - {1'b0, dsr_reg[s]};
                    q[0] = 1'b1;
                end
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1] <= r;
                quo_reg[s+1] <= q;
                dvd_reg[s+1] <= dvd_reg[s];
                dsr_reg[s+1] <= dsr_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                nz_reg[s+1]  <= nz_reg[s];
                ovf_reg[s+1] <= (s == 0) ? pre_ovf : ovf_reg[s];
                ops_reg[s+1] <= ops_reg[s];
            end
        end
    end

    // Saturate: limit is 2^(CW-1) when negative, else 2^(CW-1)-1
    logic signed [CW-1:0] t_sat;
    always_comb begin
        logic [QW-1:0] lim;
        lim = neg_reg[NS] ? QW'(64'h8000_0000) : QW'(64'h7FFF_FFFF);
        if (ovf_reg[NS] || quo_reg[NS] > lim) t_sat = neg_reg[NS] ? CW'(32'h8000_0000)
                                                                  : CW'(32'h7FFF_FFFF);
        else if (neg_reg[NS]) t_sat = CW'(-quo_reg[NS]);
        else t_sat = CW'(quo_reg[NS]);
        if (!nz_reg[NS]) t_sat = '0;
    end

    // Product stage: t * v for the two other axes
    logic signed [CW-1:0] t_p_reg;
    logic signed [PW-1:0] prod_b_reg, prod_c_reg;
    rbi_pkg::face_ops_t   ops_p_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            t_p_reg    <= t_sat;
            prod_b_reg <= PW'(t_sat) * PW'(ops_reg[NS].vel_b);
            prod_c_reg <= PW'(t_sat) * PW'(ops_reg[NS].vel_c);
            ops_p_reg  <= ops_reg[NS];
        end
    end

    // Floor shift and clamp to +-2^40, then 2p = 2*pos + 2*m
    function automatic logic signed [44:0] twice_p(input logic signed [PW-1:0] pr,
                                                   input logic signed [CW-1:0] p);
        logic signed [PW-1:0] m;
        logic signed [44:0]   mc;
        m = pr >>> FB;
        if (m > $signed(PW'(CLAMP)))       mc = 45'(CLAMP);
        else if (m < -$signed(PW'(CLAMP))) mc = -45'(CLAMP);
        else                               mc = 45'(m);
        return 45'(p) * 45'sd2 + mc * 45'sd2;
    endfunction

    logic signed [44:0]   pb_reg, pc_reg;
    logic signed [CW-1:0] t_h_reg;
    logic [rbi_pkg::SIZE_WIDTH-1:0] sb_reg, sc_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            pb_reg  <= twice_p(prod_b_reg, ops_p_reg.pos_b);
            pc_reg  <= twice_p(prod_c_reg, ops_p_reg.pos_c);
            t_h_reg <= t_p_reg;
            sb_reg  <= ops_p_reg.size_b;
            sc_reg  <= ops_p_reg.size_c;
        end
    end

    // Strict inside test on both other axes
    logic in_b, in_c;
    assign in_b = (pb_reg > -$signed({14'd0, sb_reg})) && (pb_reg < $signed({14'd0, sb_reg}));
    assign in_c = (pc_reg > -$signed({14'd0, sc_reg})) && (pc_reg < $signed({14'd0, sc_reg}));

    logic signed [CW-1:0] t_reg;
    always_ff @(posedge aclk) begin
        if (en) t_reg <= (in_b && in_c) ? t_h_reg : '0;
    end
    assign t_out = t_reg;

endmodule

### design/ray_box_intersection.sv
// Top level of the ray/box intersection pipeline: config registers, six face
// units, selection and output. Depends on rbi_pkg and rbi_face.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    rbi_pkg::ray_t     (s_ray)
//  m_        out        m_valid/m_ready    rbi_pkg::result_t  (m_result)
//  cfg       in         cfg_wr_en          cfg_index, cfg_data
//
// One ray per cycle while the output register is empty or being taken.
// The whole pipe advances when the output register is empty or being taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Reset clears the valid bits and loads box sizes of 1.0.
module ray_box_intersection (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  rbi_pkg::ray_t                    s_ray,
    output logic                             m_valid,
    input  logic                             m_ready,
    output rbi_pkg::result_t                 m_result,
    input  logic                             cfg_wr_en,
    input  logic [1:0]                       cfg_index,
    input  logic [rbi_pkg::SIZE_WIDTH-1:0]   cfg_data
);
    localparam int CW  = rbi_pkg::COORD_WIDTH;
    localparam int NW  = rbi_pkg::NUM_WIDTH;
    localparam int SW  = rbi_pkg::SIZE_WIDTH;
    localparam int LAT = rbi_pkg::DIV_STAGES + 5;   // input reg .. face output

    // Config registers
    logic [SW-1:0] size_reg [3];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) size_reg[i] <= rbi_pkg::SIZE_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                rbi_pkg::REG_BOX_SIZE_X: size_reg[0] <= cfg_data;
                rbi_pkg::REG_BOX_SIZE_Y: size_reg[1] <= cfg_data;
                rbi_pkg::REG_BOX_SIZE_Z: size_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;

    // Valid shift line
    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (adv) vld_reg <= {vld_reg[LAT-2:0], s_valid};
    end

    // Input register
    rbi_pkg::ray_t ray_reg;
    always_ff @(posedge aclk) begin
        if (adv) ray_reg <= s_ray;
    end

    logic signed [CW-1:0] pos [3];
    logic signed [CW-1:0] vel [3];
    assign pos[0] = ray_reg.pos_x;
    assign pos[1] = ray_reg.pos_y;
    assign pos[2] = ray_reg.pos_z;
    assign vel[0] = ray_reg.vel_x;
    assign vel[1] = ray_reg.vel_y;
    assign vel[2] = ray_reg.vel_z;

    // Six face units, order x-, x+, y-, y+, z-, z+
    logic signed [CW-1:0] t [6];
    for (genvar a = 0; a < 3; a++) begin : g_axis
        localparam int B = (a + 1) % 3;
        localparam int C = (a + 2) % 3;
        rbi_pkg::face_ops_t ops;
        logic signed [NW-1:0] two_p, sz, num_lo, num_hi;
        assign ops = '{pos_b: pos[B], pos_c: pos[C], vel_b: vel[B], vel_c: vel[C],
                       size_b: size_reg[B], size_c: size_reg[C]};
        assign two_p  = NW'(pos[a]) * NW'(2);
        assign sz     = NW'({1'b0, size_reg[a]});
        assign num_lo = -(sz + two_p);
        assign num_hi = sz - two_p;
        rbi_face u_lo (.aclk, .en(adv), .num(num_lo), .vel(vel[a]), .ops, .t_out(t[2*a]));
        rbi_face u_hi (.aclk, .en(adv), .num(num_hi), .vel(vel[a]), .ops, .t_out(t[2*a+1]));
    end

    // First nonzero and last nonzero after it
    rbi_pkg::result_t res_next;
    always_comb begin
        logic signed [CW-1:0] first, last;
        logic found;
        first = '0;
        last  = '0;
        found = 1'b0;
        for (int i = 0; i < 6; i++) begin
            if (t[i] != '0) begin
                if (!found) begin
                    first = t[i];
                    found = 1'b1;
                end else begin
                    last = t[i];
                end
            end
        end
        res_next.hit      = found;
        res_next.time_in  = (first < last) ? first : last;
        res_next.time_out = (first < last) ? last : first;
        if (!found) begin
            res_next.time_in  = '0;
            res_next.time_out = '0;
        end
    end

    // Output register
    logic valid_reg;
    rbi_pkg::result_t res_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) valid_reg <= 1'b0;
        else if (adv) valid_reg <= vld_reg[LAT-1];
    end
    always_ff @(posedge aclk) begin
        if (adv) res_reg <= res_next;
    end
    assign m_valid  = valid_reg;
    assign m_result = res_reg;

`ifndef SYNTH
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_result.hit |-> m_result.time_in == '0 && m_result.time_out == '0)
        else $error("miss with nonzero times");
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_result.time_in <= m_result.time_out)
        else $error("times out of order");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(vld_reg))
        else $error("pipe moved during stall");
`endif

endmodule

### verif/ray_box_intersection_test.sv
// Testbench for ray_box_intersection: directed and random rays against a
// behavioural model of the box crossing test. Depends on rbi_pkg and the RTL.
`timescale 1ns / 100ps

module ray_box_intersection_test;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam logic [rbi_pkg::SIZE_WIDTH-1:0] SIZE_MAX = 31'h7FFF_FFFF;
    localparam int PIPE_CYCLES = rbi_pkg::DIV_STAGES + 5;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_valid;
    logic                           s_ready;
    rbi_pkg::ray_t                  s_ray;
    logic                           m_valid;
    logic                           m_ready;
    rbi_pkg::result_t               m_result;
    logic                           cfg_wr_en;
    logic [1:0]                     cfg_index;
    logic [rbi_pkg::SIZE_WIDTH-1:0] cfg_data;

    // Expected crossings in order, and the box as the block should hold it
    rbi_pkg::result_t               pending_results[$];
    logic [rbi_pkg::SIZE_WIDTH-1:0] box_size[3];
    int                             mismatch_count;
    bit                             hold_req;
    bit                             cur_known;
    rbi_pkg::result_t               cur_exp;
    int                             burst_left;

    typedef struct {
        rbi_pkg::ray_t    ray;
        bit               known;
        rbi_pkg::result_t exp;
    } stim_row_t;

    stim_row_t directed[$];

    ray_box_intersection dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_ray(s_ray),
        .m_valid(m_valid), .m_ready(m_ready), .m_result(m_result),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    // Face time num / (2v) in Q16.16, truncated toward zero, saturated
    function automatic longint face_crossing(longint num, longint v);
        bit          neg;
        logic [63:0] mn, md, lim, q;
        neg = (num < 0) != (v < 0);
        mn  = (num < 0) ? -num : num;
        md  = 2 * ((v < 0) ? -v : v);
        lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        q   = (mn << rbi_pkg::FRAC_BITS) / md;
        if (q > lim) q = lim;
        return neg ? -longint'(q) : longint'(q);
    endfunction

    // floor(t * v / 2^16), magnitude clamped to 2^40
    function automatic longint travel(longint t, longint v);
        bit          neg;
        logic [63:0] a, b, prod, m;
        neg  = (t < 0) != (v < 0);
        a    = (t < 0) ? -t : t;
        b    = (v < 0) ? -v : v;
        prod = a * b;
        m    = prod >> rbi_pkg::FRAC_BITS;
        if (neg && prod[rbi_pkg::FRAC_BITS-1:0] != 0) m = m + 1;
        if (m > (64'd1 << 40)) m = 64'd1 << 40;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic rbi_pkg::result_t predict_crossing(rbi_pkg::ray_t r);
        longint           p[3], v[3], sz[3], tt, num, pb, pc, first, last;
        bit               found;
        int               b, c;
        rbi_pkg::result_t res;
        p  = '{longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z)};
        v  = '{longint'(r.vel_x), longint'(r.vel_y), longint'(r.vel_z)};
        for (int i = 0; i < 3; i++) sz[i] = longint'({1'b0, box_size[i]});
        found = 0;
        first = 0;
        last  = 0;
        for (int ax = 0; ax < 3; ax++) begin
            b = (ax + 1) % 3;
            c = (ax + 2) % 3;
            for (int f = 0; f < 2; f++) begin
                tt = 0;
                if (v[ax] != 0) begin
                    num = (f == 0) ? -(sz[ax] + 2 * p[ax]) : sz[ax] - 2 * p[ax];
                    tt  = face_crossing(num, v[ax]);
                    pb  = 2 * p[b] + 2 * travel(tt, v[b]);
                    pc  = 2 * p[c] + 2 * travel(tt, v[c]);
                    if (!(pb > -sz[b] && pb < sz[b] && pc > -sz[c] && pc < sz[c]))
                        tt = 0;
                end
                // zero times never count
                if (tt != 0) begin
                    if (!found) begin
                        first = tt;
                        found = 1;
                    end else begin
                        last = tt;
                    end
                end
            end
        end
        res = '0;
        if (found) begin
            res.hit      = 1'b1;
            res.time_in  = (first < last) ? first[31:0] : last[31:0];
            res.time_out = (first < last) ? last[31:0] : first[31:0];
        end
        return res;
    endfunction

    function automatic rbi_pkg::ray_t mk_ray(logic [31:0] px, logic [31:0] py,
                                             logic [31:0] pz, logic [31:0] vx,
                                             logic [31:0] vy, logic [31:0] vz);
        rbi_pkg::ray_t r;
        r.pos_x = px; r.pos_y = py; r.pos_z = pz;
        r.vel_x = vx; r.vel_y = vy; r.vel_z = vz;
        return r;
    endfunction

    function automatic rbi_pkg::result_t mk_res(logic h, logic [31:0] ti, logic [31:0] to);
        rbi_pkg::result_t r;
        r.hit = h; r.time_in = ti; r.time_out = to;
        return r;
    endfunction

    // Odd coordinate: full random, an extreme, or a small value
    function automatic logic [31:0] noise_coord();
        case ($urandom_range(0, 3))
            0, 1:    return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h0;
                    1: return 32'h1;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h7FFF_FFFF;
                    default: return 32'h8000_0000;
                endcase
            end
            default: return $urandom_range(0, 32'h7FFFF) - 32'h40000;
        endcase
    endfunction

    // Start point spread over the box and a little beyond it
    function automatic logic [31:0] box_coord(logic [rbi_pkg::SIZE_WIDTH-1:0] sz);
        logic [31:0] span;
        span = {1'b0, sz} + 32'd1024;
        return $urandom_range(0, span) - (span >> 1);
    endfunction

    function automatic logic [31:0] speed();
        logic [31:0] m;
        m = $urandom_range(1, (32'd1 << $urandom_range(2, 22)));
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic rbi_pkg::ray_t random_ray();
        rbi_pkg::ray_t r;
        if ($urandom_range(0, 9) < 7) begin
            r.pos_x = box_coord(box_size[0]);
            r.pos_y = box_coord(box_size[1]);
            r.pos_z = box_coord(box_size[2]);
            r.vel_x = ($urandom_range(0, 7) == 0) ? 32'h0 : speed();
            r.vel_y = ($urandom_range(0, 7) == 0) ? 32'h0 : speed();
            r.vel_z = ($urandom_range(0, 7) == 0) ? 32'h0 : speed();
        end else begin
            r = mk_ray(noise_coord(), noise_coord(), noise_coord(),
                       noise_coord(), noise_coord(), noise_coord());
        end
        return r;
    endfunction

    // Accepted transactions: queue the prediction; results: check the oldest
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_results.push_back(cur_known ? cur_exp : predict_crossing(s_ray));
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %p", m_result);
            end else begin
                rbi_pkg::result_t e;
                e = pending_results.pop_front();
                if (m_result.hit !== e.hit || m_result.time_in !== e.time_in ||
                    m_result.time_out !== e.time_out) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected hit=%0b in=%h out=%h, got hit=%b in=%h out=%h",
                                 e.hit, e.time_in, e.time_out,
                                 m_result.hit, m_result.time_in, m_result.time_out);
                end
            end
        end
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int rx_mode, cyc;
        m_ready = 1'b0;
        rx_mode = 0;
        cyc     = 0;
        forever begin
            @(negedge aclk);
            cyc++;
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (400) @(negedge aclk);
            end
            if (cyc % 60 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= $urandom_range(0, 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (cyc % 7) < 3;
            endcase
        end
    end

    task automatic write_size(logic [1:0] idx, logic [rbi_pkg::SIZE_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx != REG_UNUSED) box_size[idx] = val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one ray; bursts of random length with random gaps between them
    task automatic send_ray(rbi_pkg::ray_t r, bit known, rbi_pkg::result_t e);
        int gap;
        s_valid   <= 1'b1;
        s_ray     <= r;
        cur_known = known;
        cur_exp   = e;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
    endtask

    // Let everything drain, then allow the pipe to settle
    task automatic drain();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (PIPE_CYCLES + 4) @(negedge aclk);
    endtask

    initial begin
        logic [rbi_pkg::SIZE_WIDTH-1:0] phase_sizes[7][3];
        s_valid        = 1'b0;
        s_ray          = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = rbi_pkg::REG_BOX_SIZE_X;
        cfg_data       = '0;
        aresetn        = 1'b0;
        mismatch_count = 0;
        hold_req       = 0;
        cur_known      = 0;
        cur_exp        = '0;
        burst_left     = 8;
        box_size       = '{rbi_pkg::SIZE_RESET, rbi_pkg::SIZE_RESET, rbi_pkg::SIZE_RESET};

        // Directed table at the reset box of 1.0
        directed = '{
            '{mk_ray(0, 0, 0, 0, 0, 0), 1'b1, mk_res(1'b0, 0, 0)},
            '{mk_ray(0, 0, 0, 32'h10000, 0, 0), 1'b1, mk_res(1'b1, -32'sd32768, 32'd32768)},
            // starting on the minus face: that time is zero, single time left
            '{mk_ray(-32'sd32768, 0, 0, 32'h10000, 0, 0), 1'b1, mk_res(1'b1, 0, 32'h10000)},
            // smallest speed: both times saturate
            '{mk_ray(0, 0, 0, 1, 0, 0), 1'b1, mk_res(1'b1, 32'h8000_0000, 32'h7FFF_FFFF)},
            // passing well outside the box
            '{mk_ray(32'h40000, 32'h40000, 0, 32'h10000, 0, 0), 1'b1, mk_res(1'b0, 0, 0)},
            // grazing the y face edge: not strictly inside
            '{mk_ray(0, 32'h8000, 0, 32'h10000, 0, 0), 1'b1, mk_res(1'b0, 0, 0)},
            '{mk_ray(0, 0, 0, 0, -32'sd65536, 0), 1'b0, '0},
            '{mk_ray(0, 0, 0, 0, 0, 32'h20000), 1'b0, '0},
            '{mk_ray(0, 0, 0, 32'h10000, 32'h10000, 32'h10000), 1'b0, '0},
            '{mk_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000), 1'b0, '0},
            '{mk_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF), 1'b0, '0},
            '{mk_ray(0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000), 1'b0, '0},
            '{mk_ray(0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0, '0},
            '{mk_ray(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_3000, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hFFFF_0001), 1'b0, '0},
            '{mk_ray(32'h1000, -32'sd4096, 32'h2000, 32'h3000, -32'sd8192, 32'h1800),
              1'b0, '0}
        };

        phase_sizes = '{
            '{rbi_pkg::SIZE_RESET, rbi_pkg::SIZE_RESET, rbi_pkg::SIZE_RESET},
            '{31'd0, 31'd0, 31'd0},
            '{SIZE_MAX, SIZE_MAX, SIZE_MAX},
            '{31'd1, SIZE_MAX, 31'd0},
            '{31'h30000, 31'h8000, 31'h123456},
            '{31'h7000_0000, 31'h20000, 31'h4_0000},
            '{31'h1_8000, 31'h5_0000, 31'h2_4000}
        };

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) send_ray(directed[i].ray, directed[i].known, directed[i].exp);
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            write_size(rbi_pkg::REG_BOX_SIZE_X, phase_sizes[ph][0]);
            write_size(rbi_pkg::REG_BOX_SIZE_Y, phase_sizes[ph][1]);
            write_size(rbi_pkg::REG_BOX_SIZE_Z, phase_sizes[ph][2]);
            // the unused index must leave the box alone
            if (ph == 4) write_size(REG_UNUSED, rbi_pkg::SIZE_WIDTH'($urandom));
            if (ph == 2) hold_req = 1;
            repeat (ph == 1 ? 100 : 240) send_ray(random_ray(), 1'b0, '0);
            drain();
        end

        repeat (PIPE_CYCLES + 10) @(negedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
